@@ rtl/obdpid_pkg.sv @@
// obdpid_pkg: shared types, codes and helper functions of the pid reply decoder
package obdpid_pkg;

   localparam int KindW  = 3;
   localparam int CharW  = 8;
   localparam int CountW = 3;
   localparam int ValueW = 15;
   localparam int DataN  = 4;

   localparam logic [KindW-1:0] KIND_RPM     = 3'd0;
   localparam logic [KindW-1:0] KIND_SPEED   = 3'd1;
   localparam logic [KindW-1:0] KIND_COOLANT = 3'd2;
   localparam logic [KindW-1:0] KIND_INTAKE  = 3'd3;
   localparam logic [KindW-1:0] KIND_FUEL    = 3'd4;

   localparam logic [CountW-1:0] HDR_LEN   = 3'd4;
   localparam logic [CountW-1:0] DATA_MAX  = 3'd4;
   localparam logic [CountW-1:0] DATA_BYTE = 3'd2;

   localparam logic [CharW-1:0] CHAR_SPACE    = 8'h20;
   localparam logic [CharW-1:0] CHAR_CASE_GAP = 8'h20;
   localparam logic [CharW-1:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [CharW-1:0] CHAR_LOWER_Z  = 8'h7a;
   localparam logic [CharW-1:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [CharW-1:0] CHAR_UPPER_F  = 8'h46;
   localparam logic [CharW-1:0] CHAR_ZERO     = 8'h30;
   localparam logic [CharW-1:0] CHAR_ONE      = 8'h31;
   localparam logic [CharW-1:0] CHAR_TWO      = 8'h32;
   localparam logic [CharW-1:0] CHAR_FOUR     = 8'h34;
   localparam logic [CharW-1:0] CHAR_FIVE     = 8'h35;
   localparam logic [CharW-1:0] CHAR_NINE     = 8'h39;
   localparam logic [CharW-1:0] CHAR_UPPER_C  = 8'h43;
   localparam logic [CharW-1:0] CHAR_UPPER_D  = 8'h44;

   // fuel: floor((1000*a + 127) / 255) as one constant multiply and shift
   localparam int                FuelProdW  = 38;
   localparam int                FuelQW     = 10;
   localparam int                FuelShift  = 26;
   localparam logic [FuelProdW-1:0] FUEL_MUL  = 38'd263173000;
   localparam logic [FuelProdW-1:0] FUEL_BIAS = 38'd33422971;

   localparam logic [ValueW-1:0] TEMP_OFFSET = 15'd40;

   typedef struct packed {
      logic [KindW-1:0]              kind;
      logic                          hdr_ok;
      logic [CountW-1:0]             data_count;
      logic [DataN-1:0][CharW-1:0]   chars;
   } snap_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic logic header_hit(logic [KindW-1:0] kind, logic [1:0] pos,
                                       logic [CharW-1:0] c);
      logic [CharW-1:0] third;
      logic [CharW-1:0] fourth;
      logic             known;
      known  = 1'b1;
      third  = CHAR_ZERO;
      fourth = CHAR_UPPER_C;
      unique case (kind)
         KIND_RPM:     fourth = CHAR_UPPER_C;
         KIND_SPEED:   fourth = CHAR_UPPER_D;
         KIND_COOLANT: fourth = CHAR_FIVE;
         KIND_INTAKE:  fourth = CHAR_UPPER_F;
         KIND_FUEL: begin
            third  = CHAR_TWO;
            fourth = CHAR_UPPER_F;
         end
         default:      known = 1'b0;
      endcase
      unique case (pos)
         2'd0:    header_hit = known && (c == CHAR_FOUR);
         2'd1:    header_hit = known && (c == CHAR_ONE);
         2'd2:    header_hit = known && (c == third);
         default: header_hit = known && (c == fourth);
      endcase
   endfunction

   function automatic hex_type hex_value(logic [CharW-1:0] c);
      hex_type h;
      h.ok  = 1'b0;
      h.val = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         h.ok  = 1'b1;
         h.val = c[3:0];
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         h.ok  = 1'b1;
         h.val = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

@@ rtl/obd_pid_response_decoder_core.sv @@
// obd_pid_response_decoder_core: top level of the obd-ii pid reply decoder
// Takes one reply character per req beat and can accept a beat every cycle. A
// reply ends on the beat with req_last set; its result is presented on rsp after the
// character tracker snapshot, which loads on the edge that accepts that beat, and the
// decode and scaling stage, which holds the fuel constant multiply, have each loaded
// it in turn. Beats without req_last give no result. Both stages
// hold a finished item while the output is stalled, so up to two results can be
// waiting before req_ready drops.
module obd_pid_response_decoder_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [obdpid_pkg::KindW-1:0]         req_cmd,
   input  logic [obdpid_pkg::CharW-1:0]         req_ch,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [obdpid_pkg::KindW-1:0]         rsp_kind,
   output logic                                 rsp_valid_res,
   output logic signed [obdpid_pkg::ValueW-1:0] rsp_value
);

   logic                 snap_valid;
   logic                 snap_ready;
   obdpid_pkg::snap_type snap;

   obdpid_track u_track (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_ch     (req_ch),
      .req_last   (req_last),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   obdpid_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap          (snap),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_valid_res (rsp_valid_res),
      .rsp_value     (rsp_value)
   );

endmodule

@@ rtl/obdpid_track.sv @@
// obdpid_track: per-character header search and data capture, snapshot on last beat
module obdpid_track (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [obdpid_pkg::KindW-1:0]     req_cmd,
   input  logic [obdpid_pkg::CharW-1:0]     req_ch,
   input  logic                             req_last,
   output logic                             snap_valid,
   input  logic                             snap_ready,
   output obdpid_pkg::snap_type             snap
);

   logic                                               started_ff;
   logic [obdpid_pkg::KindW-1:0]                       kind_ff;
   logic [obdpid_pkg::CountW-1:0]                      mp_ff;
   logic [obdpid_pkg::CountW-1:0]                      dc_ff;
   logic [obdpid_pkg::DataN-1:0][obdpid_pkg::CharW-1:0] chars_ff;
   logic [obdpid_pkg::DataN-1:0][obdpid_pkg::CharW-1:0] chars_in;
   logic                                               snap_valid_ff;
   obdpid_pkg::snap_type                               snap_ff;
   obdpid_pkg::snap_type                               snap_in;

   logic [obdpid_pkg::KindW-1:0]  kind_cur;
   logic [obdpid_pkg::CountW-1:0] mp_cur;
   logic [obdpid_pkg::CountW-1:0] dc_cur;
   logic [obdpid_pkg::CountW-1:0] mp_in;
   logic [obdpid_pkg::CountW-1:0] dc_in;
   logic [obdpid_pkg::CharW-1:0]  c_fold;
   logic                          req_fire;

   assign req_ready  = !snap_valid_ff || snap_ready;
   assign req_fire   = req_valid && req_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   always_comb begin
      kind_cur = started_ff ? kind_ff : req_cmd;
      mp_cur   = started_ff ? mp_ff : '0;
      dc_cur   = started_ff ? dc_ff : '0;
      c_fold   = req_ch;
      if (req_ch >= obdpid_pkg::CHAR_LOWER_A && req_ch <= obdpid_pkg::CHAR_LOWER_Z) begin
         c_fold = req_ch - obdpid_pkg::CHAR_CASE_GAP;
      end
      mp_in    = mp_cur;
      dc_in    = dc_cur;
      chars_in = chars_ff;
      if (req_ch != obdpid_pkg::CHAR_SPACE) begin
         if (mp_cur == obdpid_pkg::HDR_LEN) begin
            if (dc_cur != obdpid_pkg::DATA_MAX) begin
               chars_in[dc_cur[1:0]] = c_fold;
               dc_in                 = dc_cur + 3'd1;
            end
         end else if (obdpid_pkg::header_hit(kind_cur, mp_cur[1:0], c_fold)) begin
            mp_in = mp_cur + 3'd1;
         end else if (c_fold == obdpid_pkg::CHAR_FOUR && kind_cur <= obdpid_pkg::KIND_FUEL) begin
            mp_in = 3'd1;
         end else begin
            mp_in = '0;
         end
      end
      snap_in.kind       = kind_cur;
      snap_in.hdr_ok     = (mp_in == obdpid_pkg::HDR_LEN);
      snap_in.data_count = dc_in;
      snap_in.chars      = chars_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff    <= 1'b0;
         kind_ff       <= '0;
         mp_ff         <= '0;
         dc_ff         <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         if (req_fire && req_last) begin
            snap_valid_ff <= 1'b1;
         end else if (snap_ready) begin
            snap_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            if (req_last) begin
               started_ff <= 1'b0;
               kind_ff    <= '0;
               mp_ff      <= '0;
               dc_ff      <= '0;
            end else begin
               started_ff <= 1'b1;
               kind_ff    <= kind_cur;
               mp_ff      <= mp_in;
               dc_ff      <= dc_in;
            end
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         chars_ff <= chars_in;
      end
      if (req_fire && req_last) begin
         snap_ff <= snap_in;
      end
   end

endmodule

@@ rtl/obdpid_decode.sv @@
// obdpid_decode: hex byte parsing and unit conversion into the result register
module obdpid_decode (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 snap_valid,
   output logic                                 snap_ready,
   input  obdpid_pkg::snap_type                 snap,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [obdpid_pkg::KindW-1:0]         rsp_kind,
   output logic                                 rsp_valid_res,
   output logic signed [obdpid_pkg::ValueW-1:0] rsp_value
);

   logic                                 rsp_valid_ff;
   logic [obdpid_pkg::KindW-1:0]         kind_ff;
   logic                                 ok_ff;
   logic signed [obdpid_pkg::ValueW-1:0] value_ff;

   obdpid_pkg::hex_type                  hi0;
   obdpid_pkg::hex_type                  lo0;
   obdpid_pkg::hex_type                  hi1;
   obdpid_pkg::hex_type                  lo1;
   logic [7:0]                           byte_a;
   logic [7:0]                           byte_b;
   logic                                 need_ok;
   logic                                 ok_in;
   logic [obdpid_pkg::FuelProdW-1:0]     fuel_prod;
   logic [obdpid_pkg::FuelQW-1:0]        fuel_q;
   logic [obdpid_pkg::ValueW-1:0]        value_in;
   logic                                 snap_fire;

   assign snap_ready    = !rsp_valid_ff || rsp_ready;
   assign snap_fire     = snap_valid && snap_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_valid_res = ok_ff;
   assign rsp_value     = value_ff;

   always_comb begin
      hi0    = obdpid_pkg::hex_value(snap.chars[0]);
      lo0    = obdpid_pkg::hex_value(snap.chars[1]);
      hi1    = obdpid_pkg::hex_value(snap.chars[2]);
      lo1    = obdpid_pkg::hex_value(snap.chars[3]);
      byte_a = lo0.ok ? {hi0.val, lo0.val} : {4'd0, hi0.val};
      byte_b = lo1.ok ? {hi1.val, lo1.val} : {4'd0, hi1.val};
      need_ok = (snap.kind == obdpid_pkg::KIND_RPM) ? (snap.data_count == obdpid_pkg::DATA_MAX)
                                                    : (snap.data_count >= obdpid_pkg::DATA_BYTE);
      ok_in = snap.hdr_ok && (snap.kind <= obdpid_pkg::KIND_FUEL) && need_ok && hi0.ok
              && (snap.kind != obdpid_pkg::KIND_RPM || hi1.ok);
      fuel_prod = {{(obdpid_pkg::FuelProdW-8){1'b0}}, byte_a} * obdpid_pkg::FUEL_MUL
                  + obdpid_pkg::FUEL_BIAS;
      fuel_q    = fuel_prod[obdpid_pkg::FuelShift +: obdpid_pkg::FuelQW];
      unique case (snap.kind)
         obdpid_pkg::KIND_RPM:     value_in = {1'b0, byte_a, byte_b[7:2]};
         obdpid_pkg::KIND_SPEED:   value_in = {7'd0, byte_a};
         obdpid_pkg::KIND_COOLANT,
         obdpid_pkg::KIND_INTAKE:  value_in = {7'd0, byte_a} - obdpid_pkg::TEMP_OFFSET;
         obdpid_pkg::KIND_FUEL:    value_in = {5'd0, fuel_q};
         default:                  value_in = '0;
      endcase
      if (!ok_in) begin
         value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (snap_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (snap_fire) begin
         kind_ff  <= snap.kind;
         ok_ff    <= ok_in;
         value_ff <= value_in;
      end
   end

endmodule

@@ test/tb_obd_pid_response_decoder_core.sv @@
// tb_obd_pid_response_decoder_core: self-checking testbench for the obd-ii pid reply decoder
module tb_obd_pid_response_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandBeats  = 1900;
   localparam int StallLimit = 4000;
   localparam int HoldCycles = 300;
   localparam int HoldAfter  = 600;
   localparam int DrainWait  = 8;

   localparam logic [obdpid_pkg::KindW-1:0] KIND_BOGUS = 3'd7;

   typedef struct {
      logic [obdpid_pkg::KindW-1:0]         kind;
      logic                                 valid_res;
      logic signed [obdpid_pkg::ValueW-1:0] value;
   } reading_type;

   typedef struct {
      logic [obdpid_pkg::KindW-1:0] cmd;
      string                        text;
      bit                           fixed_on;
      logic [obdpid_pkg::KindW-1:0] kind;
      logic                         ok;
      int                           value;
   } script_row_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic [obdpid_pkg::KindW-1:0]         req_cmd;
   logic [obdpid_pkg::CharW-1:0]         req_ch;
   logic                                 req_last;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [obdpid_pkg::KindW-1:0]         rsp_kind;
   logic                                 rsp_valid_res;
   logic signed [obdpid_pkg::ValueW-1:0] rsp_value;

   reading_type    pending_readings[$];
   script_row_type script [6];
   int             errors    = 0;
   int             beats_in  = 0;
   int             idle_run  = 0;
   int             gap_mode  = 0;

   // decoder state as seen by the predictor
   bit                           reply_open;
   logic [obdpid_pkg::KindW-1:0] reply_kind;
   int                           hdr_pos;
   int                           data_seen;
   logic [obdpid_pkg::CharW-1:0] data_buf [4];

   always #5 clock = ~clock;

   obd_pid_response_decoder_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_ch        (req_ch),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_valid_res (rsp_valid_res),
      .rsp_value     (rsp_value)
   );

   function automatic int header_at(logic [obdpid_pkg::KindW-1:0] kind, int pos);
      if (kind > obdpid_pkg::KIND_FUEL) return -1;
      case (pos)
         0: return "4";
         1: return "1";
         2: return (kind == obdpid_pkg::KIND_FUEL) ? "2" : "0";
         default: begin
            case (kind)
               obdpid_pkg::KIND_RPM:     return "C";
               obdpid_pkg::KIND_SPEED:   return "D";
               obdpid_pkg::KIND_COOLANT: return "5";
               default:                  return "F";
            endcase
         end
      endcase
   endfunction

   function automatic int hex_of(logic [obdpid_pkg::CharW-1:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic int byte_from(int i);
      int hi;
      int lo;
      hi = hex_of(data_buf[i]);
      lo = hex_of(data_buf[i + 1]);
      if (hi < 0) return -1;
      if (lo < 0) return hi;
      return hi * 16 + lo;
   endfunction

   function automatic bit decode_char(input logic [obdpid_pkg::KindW-1:0] cmd,
                                      input logic [obdpid_pkg::CharW-1:0] ch,
                                      input logic last, output reading_type r);
      logic [obdpid_pkg::CharW-1:0] c;
      int                           a;
      int                           b;
      int                           need;
      int                           v;
      bit                           ok;
      c  = ch;
      ok = 1'b0;
      v  = 0;
      if (!reply_open) begin
         reply_open = 1'b1;
         reply_kind = cmd;
         hdr_pos    = 0;
         data_seen  = 0;
      end
      if (c != obdpid_pkg::CHAR_SPACE) begin
         if (c >= obdpid_pkg::CHAR_LOWER_A && c <= obdpid_pkg::CHAR_LOWER_Z)
            c = c - obdpid_pkg::CHAR_CASE_GAP;
         if (hdr_pos >= 4) begin
            if (data_seen < 4) begin
               data_buf[data_seen] = c;
               data_seen++;
            end
         end else if (header_at(reply_kind, hdr_pos) == int'(c)) begin
            hdr_pos++;
         end else begin
            hdr_pos = (c == obdpid_pkg::CHAR_FOUR && reply_kind <= obdpid_pkg::KIND_FUEL) ? 1 : 0;
         end
      end
      r.kind      = reply_kind;
      r.valid_res = 1'b0;
      r.value     = '0;
      if (!last) return 1'b0;
      need = (reply_kind == obdpid_pkg::KIND_RPM) ? 4 : 2;
      if (hdr_pos >= 4 && reply_kind <= obdpid_pkg::KIND_FUEL && data_seen >= need) begin
         a = byte_from(0);
         b = byte_from(2);
         if (a >= 0) begin
            case (reply_kind)
               obdpid_pkg::KIND_RPM: begin
                  if (b >= 0) begin
                     ok = 1'b1;
                     v  = (a * 256 + b) / 4;
                  end
               end
               obdpid_pkg::KIND_SPEED: begin
                  ok = 1'b1;
                  v  = a;
               end
               obdpid_pkg::KIND_COOLANT, obdpid_pkg::KIND_INTAKE: begin
                  ok = 1'b1;
                  v  = a - 40;
               end
               default: begin
                  ok = 1'b1;
                  v  = (2000 * a + 255) / 510;
               end
            endcase
         end
      end
      r.valid_res = ok;
      r.value     = ok ? v[obdpid_pkg::ValueW-1:0] : '0;
      reply_open  = 1'b0;
      reply_kind  = '0;
      hdr_pos     = 0;
      data_seen   = 0;
      data_buf    = '{default: '0};
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      case (gap_mode)
         0: return 0;
         1: begin
            if (roll < 70) return 0;
            if (roll < 95) return $urandom_range(1, 3);
            return $urandom_range(10, 40);
         end
         default: begin
            if (roll < 40) return 0;
            if (roll < 90) return $urandom_range(1, 4);
            return $urandom_range(10, 40);
         end
      endcase
   endfunction

   function automatic logic [obdpid_pkg::CharW-1:0] noise_char();
      string mix;
      int    roll;
      mix  = "41 0CDF25+-";
      roll = $urandom_range(0, 99);
      if (roll < 30) return obdpid_pkg::CharW'($urandom_range(0, 255));
      if (roll < 50) return mix[$urandom_range(0, mix.len() - 1)];
      return obdpid_pkg::CharW'($urandom_range(33, 126));
   endfunction

   function automatic logic [obdpid_pkg::CharW-1:0] hex_char();
      string digits;
      digits = "0123456789ABCDEFabcdef";
      return digits[$urandom_range(0, digits.len() - 1)];
   endfunction

   task automatic send_beat(input logic [obdpid_pkg::KindW-1:0] cmd,
                            input logic [obdpid_pkg::CharW-1:0] ch,
                            input logic last, input bit fixed_on, input reading_type fixed);
      int          gap;
      reading_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_ch    <= ch;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
      beats_in++;
      if (decode_char(cmd, ch, last, r)) pending_readings.push_back(fixed_on ? fixed : r);
      if (beats_in % 150 == 0) gap_mode = $urandom_range(0, 2);
   endtask

   task automatic play_random_reply();
      logic [obdpid_pkg::CharW-1:0] q[$];
      logic [obdpid_pkg::CharW-1:0] c;
      logic [obdpid_pkg::KindW-1:0] cmd;
      logic [obdpid_pkg::KindW-1:0] hk;
      reading_type                  none;
      int                           style;
      int                           bad;
      int                           n;
      int                           k;
      none  = '{default: '0};
      style = $urandom_range(0, 99);
      cmd   = ($urandom_range(0, 99) < 88) ? obdpid_pkg::KindW'($urandom_range(0, 4))
                                           : obdpid_pkg::KindW'($urandom_range(5, 7));
      hk    = (cmd > obdpid_pkg::KIND_FUEL) ? obdpid_pkg::KindW'($urandom_range(0, 4)) : cmd;
      if (style < 85) begin
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) q.push_back(noise_char());
         end
         // broken headers are cut short at one position or have that position replaced
         bad = (style >= 68) ? $urandom_range(0, 3) : 4;
         for (k = 0; k < 4; k++) begin
            c = obdpid_pkg::CharW'(header_at(hk, k));
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
               c = c + obdpid_pkg::CHAR_CASE_GAP;
            if ($urandom_range(0, 99) < 15) q.push_back(obdpid_pkg::CHAR_SPACE);
            if (k == bad) begin
               if ($urandom_range(0, 1)) break;
               c = noise_char();
            end
            q.push_back(c);
         end
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6)
                                         : ((hk == obdpid_pkg::KIND_RPM) ? 4 : 2);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 12) q.push_back(obdpid_pkg::CHAR_SPACE);
            q.push_back(($urandom_range(0, 99) < 10) ? noise_char() : hex_char());
         end
      end else begin
         n = $urandom_range(1, 10);
         for (k = 0; k < n; k++) q.push_back(noise_char());
      end
      if (q.size() == 0) q.push_back(noise_char());
      for (k = 0; k < q.size(); k++)
         send_beat((k == 0) ? cmd : obdpid_pkg::KindW'($urandom_range(0, 7)), q[k],
                   k == q.size() - 1, 1'b0, none);
   endtask

   task automatic check_reading();
      reading_type w;
      if (pending_readings.size() == 0) begin
         $error("unexpected result beat: kind %0d valid_res %0d value %0d",
                rsp_kind, rsp_valid_res, rsp_value);
         errors++;
      end else begin
         w = pending_readings.pop_front();
         if (rsp_kind !== w.kind) begin
            $error("kind: expected %0d, got %0d", w.kind, rsp_kind);
            errors++;
         end
         if (rsp_valid_res !== w.valid_res) begin
            $error("valid_res: expected %0d, got %0d", w.valid_res, rsp_valid_res);
            errors++;
         end
         if (rsp_value !== w.value) begin
            $error("value: expected %0d, got %0d", w.value, rsp_value);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_run <= 0;
      else idle_run <= idle_run + 1;
   end

   initial begin
      while (idle_run < StallLimit) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   initial begin : rsp_side
      int stall;
      int pct;
      int cyc;
      bit held;
      rsp_ready = 1'b0;
      stall     = 0;
      pct       = 15;
      cyc       = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_reading();
         cyc++;
         if (cyc % 300 == 0) begin
            case ($urandom_range(0, 2))
               0:       pct = 0;
               1:       pct = 15;
               default: pct = 50;
            endcase
         end
         if (!held && beats_in >= HoldAfter) begin
            held  = 1'b1;
            stall = HoldCycles;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < pct) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      reading_type want;
      int          i;
      int          k;
      int          len;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_cmd    = '0;
      req_ch     = '0;
      req_last   = 1'b0;
      reply_open = 1'b0;
      reply_kind = '0;
      hdr_pos    = 0;
      data_seen  = 0;
      data_buf   = '{default: '0};
      script[0] = '{obdpid_pkg::KIND_RPM, "410cffff", 1'b1, obdpid_pkg::KIND_RPM, 1'b1, 16383};
      script[1] = '{KIND_BOGUS, "4", 1'b1, KIND_BOGUS, 1'b0, 0};
      script[2] = '{obdpid_pkg::KIND_SPEED, "410D 0g", 1'b0, obdpid_pkg::KIND_SPEED, 1'b0, 0};
      script[3] = '{obdpid_pkg::KIND_FUEL, "412FFF", 1'b1, obdpid_pkg::KIND_FUEL, 1'b1, 1000};
      script[4] = '{obdpid_pkg::KIND_COOLANT, "4105+1", 1'b1, obdpid_pkg::KIND_COOLANT,
                    1'b0, 0};
      script[5] = '{obdpid_pkg::KIND_INTAKE, "4410f00", 1'b1, obdpid_pkg::KIND_INTAKE,
                    1'b1, -40};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < 6; i++) begin
         want.kind      = script[i].kind;
         want.valid_res = script[i].ok;
         want.value     = script[i].value[obdpid_pkg::ValueW-1:0];
         len            = script[i].text.len();
         for (k = 0; k < len; k++)
            send_beat(script[i].cmd, script[i].text[k], k == len - 1, script[i].fixed_on, want);
      end
      len = beats_in + RandBeats;
      while (beats_in < len) play_random_reply();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
